>>> src/ntt8_pkg.sv
// Shared types, constants and helper functions for the 8-point NTT modulo 12289.
// Used by ntt8_lane, ntt8_stage and ntt8_mod12289. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ntt8_pkg;

  // Coefficient format and modulus
  localparam int unsigned CoefW     = 14;
  localparam int unsigned NumCoef   = 8;
  localparam int unsigned NumStages = 3;
  localparam int unsigned NumLanes  = NumCoef / 2;

  // Register levels inside one butterfly lane, and whole pipeline depth
  // (input register plus three butterfly stages)
  localparam int unsigned LaneDepth = 4;
  localparam int unsigned PipeDepth = 1 + NumStages * LaneDepth;

  localparam logic [CoefW-1:0] Q        = 14'd12289;
  // -q^-1 mod 2^16
  localparam logic [15:0]      QInvNeg  = 16'd12287;

  // Twiddles in Montgomery form; entry 0 is unused
  localparam logic [CoefW-1:0] Twiddle [0:NumCoef-1] = '{
    14'd0, 14'd7888, 14'd11060, 14'd11208, 14'd6960, 14'd4342, 14'd6275, 14'd9759
  };

  typedef logic [CoefW-1:0] coef_t;
  typedef coef_t [NumCoef-1:0] coef_vec_t;

  // Advance strobes for the register levels of one lane
  typedef struct packed {
    logic out;
    logic acc;
    logic red;
    logic mul;
  } lane_en_t;

  // One conditional subtraction of q; valid for a below 2q
  function automatic coef_t reduce_once(input logic [CoefW:0] a);
    logic [CoefW:0] diff;
    diff = a - {1'b0, Q};
    return (a >= {1'b0, Q}) ? diff[CoefW-1:0] : a[CoefW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/ntt8_lane.sv
// One Cooley-Tukey butterfly lane: Montgomery product with a twiddle, then
// u + v and u - v modulo q, over four register levels. Depends on ntt8_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ntt8_lane
  import ntt8_pkg::*;
(
  input  wire logic     clk_i,
  input  wire lane_en_t en_i,
  input  wire coef_t    u_i,
  input  wire coef_t    b_i,
  input  wire coef_t    w_i,
  output coef_t         sum_o,
  output coef_t         diff_o
);

  // level 1: full product
  coef_t       u1_q;
  logic [27:0] prod1_q;
  // level 2: Montgomery quotient
  coef_t       u2_q;
  logic [27:0] prod2_q;
  logic [15:0] m_q;
  // level 3: shifted sum
  coef_t       u3_q;
  logic [14:0] t_q;
  // level 4: butterfly results
  coef_t       sum_q;
  coef_t       diff_q;

  logic [27:0] prod_d;
  logic [15:0] m_d;
  logic [30:0] mont_sum;
  logic [14:0] t_d;
  coef_t       v;
  logic [14:0] add_w;
  logic [14:0] sub_w;
  coef_t       sum_d;
  coef_t       diff_d;

  // Multiply operand by twiddle
  assign prod_d = {14'b0, b_i} * {14'b0, w_i};

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      u1_q    <= u_i;
      prod1_q <= prod_d;
    end
  end

  // Quotient m = low(prod) * (-q^-1) mod 2^16
  assign m_d = prod1_q[15:0] * QInvNeg;

  always_ff @(posedge clk_i) begin
    if (en_i.red) begin
      u2_q    <= u1_q;
      prod2_q <= prod1_q;
      m_q     <= m_d;
    end
  end

  // Add m*q and drop the low 16 bits
  assign mont_sum = {3'b0, prod2_q} + (31'(m_q) * 31'(Q));
  assign t_d      = mont_sum[30:16];

  always_ff @(posedge clk_i) begin
    if (en_i.acc) begin
      u3_q <= u2_q;
      t_q  <= t_d;
    end
  end

  // Final reduction and butterfly add/subtract
  assign v      = reduce_once(t_q);
  assign add_w  = {1'b0, u3_q} + {1'b0, v};
  assign sub_w  = {1'b0, u3_q} + {1'b0, Q} - {1'b0, v};
  assign sum_d  = reduce_once(add_w);
  assign diff_d = (u3_q >= v) ? (u3_q - v) : sub_w[CoefW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i.out) begin
      sum_q  <= sum_d;
      diff_q <= diff_d;
    end
  end

  assign sum_o  = sum_q;
  assign diff_o = diff_q;

endmodule

`default_nettype wire

>>> src/ntt8_stage.sv
// One NTT stage: four butterfly lanes side by side, and the merge that puts
// their results back into coefficient order. Depends on ntt8_pkg, ntt8_lane.
`timescale 1ns / 1ps
`default_nettype none

module ntt8_stage
  import ntt8_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  wire logic      clk_i,
  input  wire lane_en_t  en_i,
  input  wire coef_vec_t coef_i,
  output coef_vec_t      coef_o
);

  localparam int unsigned Stride = (NumLanes >> STAGE);

  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    // pair (i, j = i + Stride) and twiddle index for lane k
    localparam int unsigned Grp  = k / Stride;
    localparam int unsigned Off  = k % Stride;
    localparam int unsigned IdxI = Grp * 2 * Stride + Off;
    localparam int unsigned IdxJ = IdxI + Stride;
    localparam int unsigned IdxW = (1 << STAGE) + Grp;

    ntt8_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .u_i    (coef_i[IdxI]),
      .b_i    (coef_i[IdxJ]),
      .w_i    (Twiddle[IdxW]),
      .sum_o  (coef_o[IdxI]),
      .diff_o (coef_o[IdxJ])
    );
  end

endmodule

`default_nettype wire

>>> src/ntt8_mod12289.sv
// Top level of the 8-point NTT modulo 12289: input register, three butterfly
// stages and the valid/advance chain. Depends on ntt8_pkg and ntt8_stage.
//
// Usage:
//   Input channel: in_valid_i / in_ready_o with coef_in_0_i .. coef_in_7_i,
//   eight 14-bit coefficients. A word is taken at an edge where both are high.
//   Output channel: out_valid_o / out_ready_i with coef_out_0_o ..
//   coef_out_7_o, the transformed coefficients, each in 0 .. 12288.
//   Path: a taken word passes through one input register, then four register
//   levels per stage for three stages: product, Montgomery quotient, shifted
//   sum, add/subtract. Throughput: one word per cycle unless the output stalls;
//   every stage holds four multiplier lanes.
//   Stall: when the receiver holds out_ready_i low the last level holds its
//   word; earlier levels keep advancing into empty slots, so in_ready_o drops
//   only once all 13 levels are full. Results leave in order of arrival.
//   Reset: rst_ni low clears all valid flags; no word is in flight after it.
`timescale 1ns / 1ps
`default_nettype none

module ntt8_mod12289
  import ntt8_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire coef_t coef_in_0_i,
  input  wire coef_t coef_in_1_i,
  input  wire coef_t coef_in_2_i,
  input  wire coef_t coef_in_3_i,
  input  wire coef_t coef_in_4_i,
  input  wire coef_t coef_in_5_i,
  input  wire coef_t coef_in_6_i,
  input  wire coef_t coef_in_7_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output coef_t      coef_out_0_o,
  output coef_t      coef_out_1_o,
  output coef_t      coef_out_2_o,
  output coef_t      coef_out_3_o,
  output coef_t      coef_out_4_o,
  output coef_t      coef_out_5_o,
  output coef_t      coef_out_6_o,
  output coef_t      coef_out_7_o
);

  logic [PipeDepth-1:0] valid_q;
  logic [PipeDepth-1:0] valid_d;
  logic [PipeDepth-1:0] adv;

  coef_vec_t in_vec;
  coef_vec_t in_q;
  coef_vec_t stage_vec [NumStages+1];

  // Advance a level when the output is taken or any level from it on is empty
  always_comb begin
    for (int k = 0; k < PipeDepth; k++) begin
      adv[k] = out_ready_i || (((~valid_q) >> k) != '0);
    end
  end

  assign in_ready_o = adv[0];

  // Shift valid flags along with the data
  always_comb begin
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < PipeDepth; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture input word, reducing each coefficient below q
  assign in_vec[0] = coef_in_0_i;
  assign in_vec[1] = coef_in_1_i;
  assign in_vec[2] = coef_in_2_i;
  assign in_vec[3] = coef_in_3_i;
  assign in_vec[4] = coef_in_4_i;
  assign in_vec[5] = coef_in_5_i;
  assign in_vec[6] = coef_in_6_i;
  assign in_vec[7] = coef_in_7_i;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      for (int k = 0; k < NumCoef; k++) begin
        in_q[k] <= reduce_once({1'b0, in_vec[k]});
      end
    end
  end

  assign stage_vec[0] = in_q;

  // Three butterfly stages, strides 4, 2 and 1
  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    lane_en_t stage_en;

    assign stage_en = adv[1 + s*LaneDepth +: LaneDepth];

    ntt8_stage #(
      .STAGE (s)
    ) u_stage (
      .clk_i  (clk_i),
      .en_i   (stage_en),
      .coef_i (stage_vec[s]),
      .coef_o (stage_vec[s+1])
    );
  end

  // Drive output word
  assign out_valid_o  = valid_q[PipeDepth-1];
  assign coef_out_0_o = stage_vec[NumStages][0];
  assign coef_out_1_o = stage_vec[NumStages][1];
  assign coef_out_2_o = stage_vec[NumStages][2];
  assign coef_out_3_o = stage_vec[NumStages][3];
  assign coef_out_4_o = stage_vec[NumStages][4];
  assign coef_out_5_o = stage_vec[NumStages][5];
  assign coef_out_6_o = stage_vec[NumStages][6];
  assign coef_out_7_o = stage_vec[NumStages][7];

  // Any empty level must let a new word in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q != '1) |-> in_ready_o)
    else $error("in_ready_o low with an empty pipeline level");

  // An accepted word lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted word lost at input register");

  // Output taken with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !valid_q[PipeDepth-2]) |=> !out_valid_o)
    else $error("output word repeated");

  // Results are always fully reduced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coef_out_0_o < Q && coef_out_1_o < Q && coef_out_2_o < Q &&
                     coef_out_3_o < Q && coef_out_4_o < Q && coef_out_5_o < Q &&
                     coef_out_6_o < Q && coef_out_7_o < Q))
    else $error("output coefficient not reduced below q");

endmodule

`default_nettype wire

>>> verif/ntt8_mod12289_checker.sv
// Checker for ntt8_mod12289: watches both channels, predicts each transformed
// word and compares it field by field. Depends on ntt8_pkg.
`timescale 1ns / 1ps

module ntt8_mod12289_checker
  import ntt8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  coef_vec_t coef_in_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  coef_vec_t coef_out_i,
  output int        pending_o,
  output int        mismatches_o
);

  // Butterfly schedule: top index, bottom index and Montgomery-form twiddle.
  // Stride 4 first, then stride 2, then adjacent pairs.
  localparam int unsigned BflyTop [0:11] = '{0, 1, 2, 3, 0, 1, 4, 5, 0, 2, 4, 6};
  localparam int unsigned BflyBot [0:11] = '{4, 5, 6, 7, 2, 3, 6, 7, 1, 3, 5, 7};
  localparam logic [CoefW-1:0] BflyTw [0:11] = '{
    14'd7888, 14'd7888, 14'd7888, 14'd7888,
    14'd11060, 14'd11060, 14'd11208, 14'd11208,
    14'd6960, 14'd4342, 14'd6275, 14'd9759
  };

  coef_vec_t spectrum_q [$];
  coef_vec_t want;
  int        errors;

  // Single conditional subtraction; argument must be below 2q
  function automatic logic [31:0] fold_q(input logic [31:0] a);
    return (a >= 32'(Q)) ? a - 32'(Q) : a;
  endfunction

  // Forward 8-point transform mod q with Montgomery twiddle products
  function automatic coef_vec_t ntt_forward(input coef_vec_t x);
    logic [31:0] c [0:7];
    logic [31:0] prod;
    logic [31:0] top;
    logic [31:0] v;
    logic [15:0] quot;
    coef_vec_t   y;
    for (int k = 0; k < 8; k++) begin
      c[k] = fold_q(32'(x[k]));
    end
    for (int b = 0; b < 12; b++) begin
      top  = c[BflyTop[b]];
      prod = c[BflyBot[b]] * 32'(BflyTw[b]);
      quot = prod[15:0] * QInvNeg;
      v    = fold_q((prod + 32'(quot) * 32'(Q)) >> 16);
      c[BflyTop[b]] = fold_q(top + v);
      c[BflyBot[b]] = (top >= v) ? top - v : top + 32'(Q) - v;
    end
    for (int k = 0; k < 8; k++) begin
      y[k] = c[k][CoefW-1:0];
    end
    return y;
  endfunction

  // Queue a prediction per accepted input word, check each output word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spectrum_q.delete();
      errors = 0;
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        spectrum_q.push_back(ntt_forward(coef_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (spectrum_q.size() == 0) begin
          $display("%0t: output word with none expected: %h", $time, coef_out_i);
          errors++;
        end else begin
          want = spectrum_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (coef_out_i[k] !== want[k]) begin
              $display("%0t: coef_out_%0d expected %0d actual %0d",
                       $time, k, want[k], coef_out_i[k]);
              errors++;
            end
          end
        end
      end
      pending_o <= spectrum_q.size();
      mismatches_o <= errors;
    end
  end

endmodule

>>> verif/ntt8_mod12289_test.sv
// Testbench top for ntt8_mod12289: clock, reset, directed and random input
// words, random output stalls and the verdict. Depends on ntt8_pkg and
// ntt8_mod12289_checker.
`timescale 1ns / 1ps

module ntt8_mod12289_test;
  import ntt8_pkg::*;

  localparam coef_t CoefMax    = {CoefW{1'b1}};
  localparam int    RandWords  = 800;
  localparam int    CycleLimit = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  coef_vec_t in_vec = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  wire coef_vec_t out_vec;
  int        pending;
  int        mismatches;
  int        send_idle_pct = 14;
  int        recv_idle_pct = 46;
  int        cycles = 0;

  always #5 clk = ~clk;

  ntt8_mod12289 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .coef_in_0_i (in_vec[0]),
    .coef_in_1_i (in_vec[1]),
    .coef_in_2_i (in_vec[2]),
    .coef_in_3_i (in_vec[3]),
    .coef_in_4_i (in_vec[4]),
    .coef_in_5_i (in_vec[5]),
    .coef_in_6_i (in_vec[6]),
    .coef_in_7_i (in_vec[7]),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .coef_out_0_o(out_vec[0]),
    .coef_out_1_o(out_vec[1]),
    .coef_out_2_o(out_vec[2]),
    .coef_out_3_o(out_vec[3]),
    .coef_out_4_o(out_vec[4]),
    .coef_out_5_o(out_vec[5]),
    .coef_out_6_o(out_vec[6]),
    .coef_out_7_o(out_vec[7])
  );

  ntt8_mod12289_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .coef_in_i   (in_vec),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .coef_out_i  (out_vec),
    .pending_o   (pending),
    .mismatches_o(mismatches)
  );

  // Stall the output channel at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly reduced values, with extremes and unreduced ones mixed in
  function automatic coef_t rand_coef();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? Q - 14'd1 : 14'd0;
      1: return coef_t'($urandom_range(16383, 12289));
      2: return coef_t'($urandom_range(16383));
      default: return coef_t'($urandom_range(12288));
    endcase
  endfunction

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input coef_vec_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_vec <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every outstanding word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    coef_vec_t w;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: extremes, unreduced inputs, patterns and impulses
    for (int n = 0; n < 18; n++) begin
      for (int k = 0; k < 8; k++) begin
        case (n)
          0: w[k] = '0;
          1: w[k] = 14'd1;
          2: w[k] = Q - 14'd1;
          3: w[k] = Q;
          4: w[k] = CoefMax;
          5: w[k] = k[0] ? 14'd0 : Q - 14'd1;
          6: w[k] = k[0] ? CoefMax : 14'd0;
          7: w[k] = coef_t'(k);
          16: w[k] = Q - 14'd1 - coef_t'(k);
          17: w[k] = (k < 4) ? Q - 14'd1 : CoefMax;
          default: w[k] = (k == n - 8) ? 14'd1 : 14'd0;
        endcase
      end
      send_word(w);
    end
    drain();

    // Random words in three idling phases
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 14; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int i = 0; i < RandWords / 3; i++) begin
        for (int k = 0; k < 8; k++) begin
          w[k] = rand_coef();
        end
        send_word(w);
      end
      drain();
    end

    // Let any stray word surface before the verdict
    repeat (PipeDepth + 4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
src/ntt8_pkg.sv
src/ntt8_lane.sv
src/ntt8_stage.sv
src/ntt8_mod12289.sv
verif/ntt8_mod12289_checker.sv
verif/ntt8_mod12289_test.sv
